// ----- src/bcd_string_arithmetic_unit_core_macros.svh -----
`ifndef BCD_STRING_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define BCD_STRING_ARITHMETIC_UNIT_CORE_MACROS_SVH

// same-cycle implication
`define BSAU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSAU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bsau_pkg.sv -----
package bsau_pkg;

   localparam int FILE_DEPTH      = 128;
   localparam int ADDR_W          = $clog2(FILE_DEPTH);
   localparam int LENGTH_REG_ADDR = 0;
   localparam int ACC_REG_ADDR    = 2;

   typedef logic [ADDR_W-1:0] addr_type;

   localparam logic [3:0] KIND_WRITE    = 4'd0;
   localparam logic [3:0] KIND_READ     = 4'd1;
   localparam logic [3:0] KIND_SET_PTR  = 4'd2;
   localparam logic [3:0] KIND_ADD_ACC  = 4'd3;
   localparam logic [3:0] KIND_ADD_STR  = 4'd4;
   localparam logic [3:0] KIND_SUB_ACC  = 4'd5;
   localparam logic [3:0] KIND_SUB_STR  = 4'd6;
   localparam logic [3:0] KIND_SHIFT_L  = 4'd7;
   localparam logic [3:0] KIND_SHIFT_R  = 4'd8;

   typedef logic [2:0] rsel_type;
   localparam rsel_type RSEL_ADDR = 3'd0;
   localparam rsel_type RSEL_LEN  = 3'd1;
   localparam rsel_type RSEL_ACC  = 3'd2;
   localparam rsel_type RSEL_P    = 3'd3;
   localparam rsel_type RSEL_Q    = 3'd4;

   typedef logic [1:0] rclass_type;
   localparam rclass_type RES_NONE  = 2'd0;
   localparam rclass_type RES_READ  = 2'd1;
   localparam rclass_type RES_BCD   = 2'd2;
   localparam rclass_type RES_SHIFT = 2'd3;

   typedef struct packed {
      logic       accept;
      logic       wr_byte;
      logic       rd_en;
      rsel_type   rd_sel;
      logic       set_ptr;
      logic       ld_len;
      logic       ld_acc;
      logic       walk_init;
      logic       bcd_init;
      logic       ld_a;
      logic       bcd_step;
      logic       shift_step;
      logic       sub;
      logic       use_q;
      logic       shift_right;
      logic       rsp_load;
      rclass_type res_class;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic rsp_free;
   } status_type;

endpackage

// ----- src/bcd_string_arithmetic_unit_core.sv -----
// channel | ports                                              | direction
// --------+----------------------------------------------------+----------
// req     | req_valid req_stall req_kind req_address req_data  | in
//         | req_p_value req_q_value                            |
// rsp     | rsp_valid rsp_stall rsp_read_data rsp_carry_flag   | out
//         | rsp_zero_flag rsp_p_after rsp_q_after rsp_cycle_cost|
//
// One item at a time. BCD kinds and shifts walk L+1 bytes, L = length byte;
// the single read port of the register file sets the per-byte cost.
// Reset clears pointers, flags and the per-byte valid bits of the file at once.
// A stalled result waits in the output register; the next item is taken meanwhile.
module bcd_string_arithmetic_unit_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_kind,
   input  logic [6:0] req_address,
   input  logic [7:0] req_data,
   input  logic [6:0] req_p_value,
   input  logic [6:0] req_q_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_carry_flag,
   output logic       rsp_zero_flag,
   output logic [6:0] rsp_p_after,
   output logic [6:0] rsp_q_after,
   output logic [9:0] rsp_cycle_cost
);

   bsau_pkg::cmd_type    cmd;
   bsau_pkg::status_type status;

   bsau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bsau_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_address    (req_address),
      .req_data       (req_data),
      .req_p_value    (req_p_value),
      .req_q_value    (req_q_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_carry_flag (rsp_carry_flag),
      .rsp_zero_flag  (rsp_zero_flag),
      .rsp_p_after    (rsp_p_after),
      .rsp_q_after    (rsp_q_after),
      .rsp_cycle_cost (rsp_cycle_cost)
   );

endmodule

// ----- src/bsau_ctrl.sv -----
module bsau_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [3:0]           req_kind,
   output logic                 req_stall,
   input  bsau_pkg::status_type status,
   output bsau_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_WRB  = 4'd1;
   localparam logic [3:0] ST_RDRQ = 4'd2;
   localparam logic [3:0] ST_SETP = 4'd3;
   localparam logic [3:0] ST_RLEN = 4'd4;
   localparam logic [3:0] ST_RACC = 4'd5;
   localparam logic [3:0] ST_LACC = 4'd6;
   localparam logic [3:0] ST_RDA  = 4'd7;
   localparam logic [3:0] ST_RDB  = 4'd8;
   localparam logic [3:0] ST_EXEC = 4'd9;
   localparam logic [3:0] ST_SHW  = 4'd10;
   localparam logic [3:0] ST_FIN  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [3:0] kind_ff, kind_in;
   logic       is_bcd, is_shift;

   assign is_bcd   = (kind_ff == bsau_pkg::KIND_ADD_ACC) || (kind_ff == bsau_pkg::KIND_ADD_STR) ||
                     (kind_ff == bsau_pkg::KIND_SUB_ACC) || (kind_ff == bsau_pkg::KIND_SUB_STR);
   assign is_shift = (kind_ff == bsau_pkg::KIND_SHIFT_L) || (kind_ff == bsau_pkg::KIND_SHIFT_R);

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      cmd.sub  = (kind_ff == bsau_pkg::KIND_SUB_ACC) || (kind_ff == bsau_pkg::KIND_SUB_STR);
      cmd.use_q = (kind_ff == bsau_pkg::KIND_ADD_STR) || (kind_ff == bsau_pkg::KIND_SUB_STR);
      cmd.shift_right = (kind_ff == bsau_pkg::KIND_SHIFT_R);
      if (kind_ff == bsau_pkg::KIND_READ) begin
         cmd.res_class = bsau_pkg::RES_READ;
      end else if (is_bcd) begin
         cmd.res_class = bsau_pkg::RES_BCD;
      end else if (is_shift) begin
         cmd.res_class = bsau_pkg::RES_SHIFT;
      end else begin
         cmd.res_class = bsau_pkg::RES_NONE;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               kind_in    = req_kind;
               unique case (req_kind)
                  bsau_pkg::KIND_WRITE:   state_in = ST_WRB;
                  bsau_pkg::KIND_READ:    state_in = ST_RDRQ;
                  bsau_pkg::KIND_SET_PTR: state_in = ST_SETP;
                  bsau_pkg::KIND_ADD_ACC, bsau_pkg::KIND_ADD_STR,
                  bsau_pkg::KIND_SUB_ACC, bsau_pkg::KIND_SUB_STR,
                  bsau_pkg::KIND_SHIFT_L, bsau_pkg::KIND_SHIFT_R: state_in = ST_RLEN;
                  default:                state_in = ST_FIN;
               endcase
            end
         end
         ST_WRB: begin
            cmd.wr_byte = 1'b1;
            state_in    = ST_FIN;
         end
         ST_RDRQ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = bsau_pkg::RSEL_ADDR;
            state_in   = ST_FIN;
         end
         ST_SETP: begin
            cmd.set_ptr = 1'b1;
            state_in    = ST_FIN;
         end
         ST_RLEN: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = bsau_pkg::RSEL_LEN;
            state_in   = ST_RACC;
         end
         ST_RACC: begin
            cmd.ld_len   = 1'b1;
            cmd.bcd_init = is_bcd;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = bsau_pkg::RSEL_ACC;
            state_in     = ST_LACC;
         end
         ST_LACC, ST_RDA: begin
            cmd.ld_acc    = (state_ff == ST_LACC);
            cmd.walk_init = (state_ff == ST_LACC);
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = bsau_pkg::RSEL_P;
            state_in      = is_shift ? ST_SHW : ST_RDB;
         end
         ST_RDB: begin
            cmd.ld_a   = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = bsau_pkg::RSEL_Q;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.bcd_step = 1'b1;
            state_in     = status.last ? ST_FIN : ST_RDA;
         end
         ST_SHW: begin
            cmd.shift_step = 1'b1;
            state_in       = status.last ? ST_FIN : ST_RDA;
         end
         ST_FIN: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= bsau_pkg::KIND_WRITE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ----- src/bsau_datapath.sv -----
module bsau_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bsau_pkg::cmd_type    cmd,
   output bsau_pkg::status_type status,
   input  logic [6:0]           req_address,
   input  logic [7:0]           req_data,
   input  logic [6:0]           req_p_value,
   input  logic [6:0]           req_q_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_read_data,
   output logic                 rsp_carry_flag,
   output logic                 rsp_zero_flag,
   output logic [6:0]           rsp_p_after,
   output logic [6:0]           rsp_q_after,
   output logic [9:0]           rsp_cycle_cost
);

   localparam bsau_pkg::addr_type LEN_ADDR = bsau_pkg::ADDR_W'(bsau_pkg::LENGTH_REG_ADDR);
   localparam bsau_pkg::addr_type ACC_ADDR = bsau_pkg::ADDR_W'(bsau_pkg::ACC_REG_ADDR);

   logic [7:0] file_mem_ff [bsau_pkg::FILE_DEPTH];
   logic [bsau_pkg::FILE_DEPTH-1:0] fvalid_ff, fvalid_in;
   logic [7:0] rd_ff;
   logic       rd_valid_ff;
   logic [7:0] mem_rd;

   bsau_pkg::addr_type addr_ff, addr_in, pv_ff, pv_in, qv_ff, qv_in;
   logic [7:0]         data_ff, data_in;
   bsau_pkg::addr_type p_ff, p_in, q_ff, q_in;
   logic               carry_ff, carry_in, zero_ff, zero_in;
   logic [8:0]         count_ff, count_in, rem_ff, rem_in;
   logic [7:0]         acc_ff, acc_in, a_ff, a_in;
   logic [3:0]         nib_ff, nib_in;
   logic               first_ff, first_in;

   logic               rv_ff, rv_in;
   logic [7:0]         ord_ff, ord_in;
   logic               oc_ff, oc_in, oz_ff, oz_in;
   bsau_pkg::addr_type op_ff, op_in, oq_ff, oq_in;
   logic [9:0]         ocost_ff, ocost_in;

   bsau_pkg::addr_type raddr, waddr;
   logic               we;
   logic [7:0]         wdata;

   logic [7:0] b_op;
   logic [5:0] lo_raw, lo_fix, hi_raw, hi_fix;
   logic       lo_adj, hi_adj;
   logic [7:0] bcd_res;

   assign mem_rd          = rd_valid_ff ? rd_ff : 8'd0;
   assign status.last     = (rem_ff == 9'd1);
   assign status.rsp_free = !rv_ff || !rsp_stall;

   always_comb begin
      unique case (cmd.rd_sel)
         bsau_pkg::RSEL_ADDR: raddr = addr_ff;
         bsau_pkg::RSEL_LEN:  raddr = LEN_ADDR;
         bsau_pkg::RSEL_ACC:  raddr = ACC_ADDR;
         bsau_pkg::RSEL_P:    raddr = p_ff;
         bsau_pkg::RSEL_Q:    raddr = q_ff;
         default:             raddr = p_ff;
      endcase
   end

   // one BCD byte: low digit, then high digit with the digit carry
   always_comb begin
      b_op = cmd.use_q ? mem_rd : (first_ff ? acc_ff : 8'd0);
      if (cmd.sub) begin
         lo_raw = {2'b00, a_ff[3:0]} - {2'b00, b_op[3:0]} - {5'd0, carry_ff};
         lo_adj = lo_raw[5];
         lo_fix = lo_adj ? lo_raw + 6'd10 : lo_raw;
         hi_raw = {2'b00, a_ff[7:4]} - {2'b00, b_op[7:4]} - {5'd0, lo_adj};
         hi_adj = hi_raw[5];
         hi_fix = hi_adj ? hi_raw + 6'd10 : hi_raw;
      end else begin
         lo_raw = {2'b00, a_ff[3:0]} + {2'b00, b_op[3:0]} + {5'd0, carry_ff};
         lo_adj = (lo_raw > 6'd9);
         lo_fix = lo_adj ? lo_raw - 6'd10 : lo_raw;
         hi_raw = {2'b00, a_ff[7:4]} + {2'b00, b_op[7:4]} + {5'd0, lo_adj};
         hi_adj = (hi_raw > 6'd9);
         hi_fix = hi_adj ? hi_raw - 6'd10 : hi_raw;
      end
      bcd_res = {hi_fix[3:0], 4'b0000} + {{2{lo_fix[5]}}, lo_fix};
   end

   always_comb begin
      addr_in   = addr_ff;
      data_in   = data_ff;
      pv_in     = pv_ff;
      qv_in     = qv_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      carry_in  = carry_ff;
      zero_in   = zero_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      acc_in    = acc_ff;
      a_in      = a_ff;
      nib_in    = nib_ff;
      first_in  = first_ff;
      fvalid_in = fvalid_ff;
      we        = 1'b0;
      waddr     = p_ff;
      wdata     = bcd_res;
      rv_in     = rv_ff && rsp_stall;
      ord_in    = ord_ff;
      oc_in     = oc_ff;
      oz_in     = oz_ff;
      op_in     = op_ff;
      oq_in     = oq_ff;
      ocost_in  = ocost_ff;

      if (cmd.accept) begin
         addr_in = req_address[bsau_pkg::ADDR_W-1:0];
         data_in = req_data;
         pv_in   = req_p_value[bsau_pkg::ADDR_W-1:0];
         qv_in   = req_q_value[bsau_pkg::ADDR_W-1:0];
      end
      if (cmd.wr_byte) begin
         we    = 1'b1;
         waddr = addr_ff;
         wdata = data_ff;
      end
      if (cmd.set_ptr) begin
         p_in = pv_ff;
         q_in = qv_ff;
      end
      if (cmd.ld_len) begin
         count_in = {1'b0, mem_rd} + 9'd1;
         rem_in   = {1'b0, mem_rd} + 9'd1;
      end
      if (cmd.bcd_init) begin
         carry_in = 1'b0;
         zero_in  = 1'b1;
      end
      if (cmd.ld_acc) begin
         acc_in = mem_rd;
      end
      if (cmd.walk_init) begin
         nib_in   = 4'd0;
         first_in = 1'b1;
      end
      if (cmd.ld_a) begin
         a_in = mem_rd;
      end
      if (cmd.bcd_step) begin
         we       = 1'b1;
         wdata    = bcd_res;
         carry_in = hi_adj;
         if (bcd_res != 8'd0) begin
            zero_in = 1'b0;
         end
         p_in     = p_ff - bsau_pkg::ADDR_W'(1);
         if (cmd.use_q) begin
            q_in = status.last ? q_ff - bsau_pkg::ADDR_W'(2) : q_ff - bsau_pkg::ADDR_W'(1);
         end
         rem_in   = rem_ff - 9'd1;
         first_in = 1'b0;
      end
      if (cmd.shift_step) begin
         we = 1'b1;
         if (cmd.shift_right) begin
            wdata  = {nib_ff, mem_rd[7:4]};
            nib_in = mem_rd[3:0];
            p_in   = p_ff + bsau_pkg::ADDR_W'(1);
         end else begin
            wdata  = {mem_rd[3:0], nib_ff};
            nib_in = mem_rd[7:4];
            p_in   = p_ff - bsau_pkg::ADDR_W'(1);
         end
         rem_in = rem_ff - 9'd1;
      end
      if (we) begin
         fvalid_in[waddr] = 1'b1;
      end
      if (cmd.rsp_load) begin
         rv_in  = 1'b1;
         ord_in = (cmd.res_class == bsau_pkg::RES_READ) ? mem_rd : 8'd0;
         oc_in  = carry_ff;
         oz_in  = zero_ff;
         op_in  = p_ff;
         oq_in  = q_ff;
         unique case (cmd.res_class)
            bsau_pkg::RES_BCD:   ocost_in = {1'b0, count_ff} + {count_ff, 1'b0};
            bsau_pkg::RES_SHIFT: ocost_in = {1'b0, count_ff};
            default:             ocost_in = 10'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         file_mem_ff[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_ff       <= file_mem_ff[raddr];
         rd_valid_ff <= fvalid_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff <= '0;
         p_ff      <= '0;
         q_ff      <= '0;
         carry_ff  <= 1'b0;
         zero_ff   <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         fvalid_ff <= fvalid_in;
         p_ff      <= p_in;
         q_ff      <= q_in;
         carry_ff  <= carry_in;
         zero_ff   <= zero_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      data_ff  <= data_in;
      pv_ff    <= pv_in;
      qv_ff    <= qv_in;
      count_ff <= count_in;
      rem_ff   <= rem_in;
      acc_ff   <= acc_in;
      a_ff     <= a_in;
      nib_ff   <= nib_in;
      first_ff <= first_in;
      ord_ff   <= ord_in;
      oc_ff    <= oc_in;
      oz_ff    <= oz_in;
      op_ff    <= op_in;
      oq_ff    <= oq_in;
      ocost_ff <= ocost_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_read_data  = ord_ff;
   assign rsp_carry_flag = oc_ff;
   assign rsp_zero_flag  = oz_ff;
   assign rsp_p_after    = 7'(op_ff);
   assign rsp_q_after    = 7'(oq_ff);
   assign rsp_cycle_cost = ocost_ff;

endmodule

// ----- src/bsau_checker.sv -----
`include "bcd_string_arithmetic_unit_core_macros.svh"

module bsau_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_read_data,
   input logic [9:0] rsp_cycle_cost
);

   `BSAU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "item accepted but next one not held off")

   `BSAU_ASSERT_NOW(a_cost_range, clock, reset, rsp_valid, rsp_cycle_cost <= 10'd768, "cycle cost out of range")

   `BSAU_ASSERT_NOW(a_walk_no_read, clock, reset, rsp_valid && (rsp_cycle_cost != 10'd0), rsp_read_data == 8'd0, "string item returned read data")

   `BSAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_cycle_cost) && $stable(rsp_read_data), "stalled item changed")

endmodule

bind bcd_string_arithmetic_unit_core bsau_checker u_bsau_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_read_data  (rsp_read_data),
   .rsp_cycle_cost (rsp_cycle_cost)
);

// ----- verif/tb_bcd_string_arithmetic_unit_core.sv -----
`timescale 1ns / 100ps

module tb_bcd_string_arithmetic_unit_core;
   import bsau_pkg::*;

   localparam logic [3:0] KIND_UNUSED_FIRST = 4'd9;
   localparam logic [3:0] KIND_UNUSED_LAST  = 4'd15;
   localparam int RANDOM_ITEMS   = 1100;
   localparam int QUIET_ITEMS    = 120;
   localparam int LONG_HOLD      = 300;
   localparam int END_CYCLES     = 800;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic [3:0] kind;
      logic [6:0] address;
      logic [7:0] data;
      logic [6:0] p_value;
      logic [6:0] q_value;
   } item_t;

   typedef struct packed {
      logic [7:0] read_data;
      logic       carry;
      logic       zero;
      logic [6:0] p_after;
      logic [6:0] q_after;
      logic [9:0] cost;
   } outcome_t;

   typedef struct packed {
      item_t    stim;
      logic     fixed;
      outcome_t want;
   } drow_t;

   localparam outcome_t ALL_ZERO = '0;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [3:0] req_kind = KIND_WRITE;
   logic [6:0] req_address = '0;
   logic [7:0] req_data = '0;
   logic [6:0] req_p_value = '0;
   logic [6:0] req_q_value = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_carry_flag;
   logic       rsp_zero_flag;
   logic [6:0] rsp_p_after;
   logic [6:0] rsp_q_after;
   logic [9:0] rsp_cycle_cost;

   // travels with the item: a typed-in result for directed rows
   logic     row_fixed = 1'b0;
   outcome_t row_fixed_result = '0;

   logic [7:0] bcd_file [FILE_DEPTH];
   logic [6:0] p_ptr;
   logic [6:0] q_ptr;
   logic       carry_q;
   logic       zero_q;

   outcome_t pending_outcomes [$];
   int unsigned errors = 0;
   int unsigned items_sent = 0;
   int unsigned quiet_cycles = 0;
   bit idle_on = 1'b1;
   bit long_hold_req = 1'b0;

   bcd_string_arithmetic_unit_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_address    (req_address),
      .req_data       (req_data),
      .req_p_value    (req_p_value),
      .req_q_value    (req_q_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_carry_flag (rsp_carry_flag),
      .rsp_zero_flag  (rsp_zero_flag),
      .rsp_p_after    (rsp_p_after),
      .rsp_q_after    (rsp_q_after),
      .rsp_cycle_cost (rsp_cycle_cost)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_state();
      for (int i = 0; i < FILE_DEPTH; i++) bcd_file[i] = '0;
      p_ptr   = '0;
      q_ptr   = '0;
      carry_q = 1'b0;
      zero_q  = 1'b0;
   endfunction

   function automatic outcome_t run_instruction(item_t it);
      outcome_t   res;
      int         count;
      int         acc_byte;
      int         cy;
      int         lo;
      int         hi;
      int         a;
      int         b;
      logic [7:0] old;
      logic [7:0] byte_out;
      logic [3:0] nib;
      bit         sub;
      bit         use_q;
      res      = '0;
      count    = int'(bcd_file[LENGTH_REG_ADDR]) + 1;
      acc_byte = int'(bcd_file[ACC_REG_ADDR]);
      sub      = (it.kind == KIND_SUB_ACC) || (it.kind == KIND_SUB_STR);
      use_q    = (it.kind == KIND_ADD_STR) || (it.kind == KIND_SUB_STR);
      case (it.kind)
         KIND_WRITE: bcd_file[it.address] = it.data;
         KIND_READ: res.read_data = bcd_file[it.address];
         KIND_SET_PTR: begin
            p_ptr = it.p_value;
            q_ptr = it.q_value;
         end
         KIND_ADD_ACC, KIND_ADD_STR, KIND_SUB_ACC, KIND_SUB_STR: begin
            cy     = 0;
            zero_q = 1'b1;
            for (int i = 0; i < count; i++) begin
               a = int'(bcd_file[p_ptr]);
               if (use_q) begin
                  b     = int'(bcd_file[q_ptr]);
                  q_ptr = q_ptr - 7'd1;
               end else begin
                  b = (i == 0) ? acc_byte : 0;
               end
               if (!sub) begin
                  lo = (a & 'h0f) + (b & 'h0f) + cy;
                  if (lo > 9) begin
                     lo -= 'h0a;
                     cy = 'h10;
                  end else begin
                     cy = 0;
                  end
                  hi = (a & 'hf0) + (b & 'hf0) + cy;
                  if (hi > 'h90) begin
                     hi -= 'ha0;
                     cy = 1;
                  end else begin
                     cy = 0;
                  end
               end else begin
                  lo = (a & 'h0f) - (b & 'h0f) - cy;
                  if (lo < 0) begin
                     lo += 'h0a;
                     cy = 'h10;
                  end else begin
                     cy = 0;
                  end
                  hi = (a & 'hf0) - (b & 'hf0) - cy;
                  if (hi < 0) begin
                     hi += 'ha0;
                     cy = 1;
                  end else begin
                     cy = 0;
                  end
               end
               byte_out = 8'(hi + lo);
               bcd_file[p_ptr] = byte_out;
               if (byte_out != 8'd0) zero_q = 1'b0;
               p_ptr = p_ptr - 7'd1;
            end
            carry_q = (cy != 0);
            if (use_q) q_ptr = q_ptr - 7'd1;
            res.cost = 10'(3 * count);
         end
         KIND_SHIFT_L: begin
            nib = '0;
            for (int i = 0; i < count; i++) begin
               old = bcd_file[p_ptr];
               bcd_file[p_ptr] = {old[3:0], nib};
               nib   = old[7:4];
               p_ptr = p_ptr - 7'd1;
            end
            res.cost = 10'(count);
         end
         KIND_SHIFT_R: begin
            nib = '0;
            for (int i = 0; i < count; i++) begin
               old = bcd_file[p_ptr];
               bcd_file[p_ptr] = {nib, old[7:4]};
               nib   = old[3:0];
               p_ptr = p_ptr + 7'd1;
            end
            res.cost = 10'(count);
         end
         default: ;
      endcase
      res.carry   = carry_q;
      res.zero    = zero_q;
      res.p_after = p_ptr;
      res.q_after = q_ptr;
      return res;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // scoreboard and watchdog
   always @(posedge clock) begin : monitor
      item_t    seen;
      outcome_t want;
      outcome_t got;
      if (reset) begin
         clear_state();
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               errors++;
               $display("%0t ns: result with no item outstanding", $time);
            end else begin
               want = pending_outcomes.pop_front();
               got  = {rsp_read_data, rsp_carry_flag, rsp_zero_flag,
                       rsp_p_after, rsp_q_after, rsp_cycle_cost};
               check_field("read_data", want.read_data, got.read_data);
               check_field("carry_flag", want.carry, got.carry);
               check_field("zero_flag", want.zero, got.zero);
               check_field("p_after", want.p_after, got.p_after);
               check_field("q_after", want.q_after, got.q_after);
               check_field("cycle_cost", want.cost, got.cost);
            end
         end
         if (req_valid && !req_stall) begin
            seen = {req_kind, req_address, req_data, req_p_value, req_q_value};
            want = run_instruction(seen);
            pending_outcomes.push_back(row_fixed ? row_fixed_result : want);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
               $display("bcd_string_arithmetic_unit_core verification failed");
               $finish;
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      forever begin
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   task automatic send_item(item_t it, logic fixed, outcome_t fixed_res);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= it.kind;
      req_address      <= it.address;
      req_data         <= it.data;
      req_p_value      <= it.p_value;
      req_q_value      <= it.q_value;
      row_fixed        <= fixed;
      row_fixed_result <= fixed_res;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic issue(logic [3:0] kind, int addr, int data, int p, int q);
      send_item({kind, 7'(addr), 8'(data), 7'(p), 7'(q)}, 1'b0, ALL_ZERO);
   endtask

   function automatic drow_t row(logic [3:0] kind, int addr, int data, int p, int q,
                                 logic fixed, outcome_t want);
      return {kind, 7'(addr), 8'(data), 7'(p), 7'(q), fixed, want};
   endfunction

   function automatic logic [7:0] pick_operand();
      if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
   endfunction

   // length, accumulator, pointers, operands, the walk, then read back
   task automatic issue_sequence();
      logic [3:0] op;
      int         pick;
      int         len;
      int         span;
      int         p;
      int         q;
      bit         upward;
      bit         use_q;
      op     = 4'($urandom_range(KIND_ADD_ACC, KIND_SHIFT_R));
      pick   = $urandom_range(0, 99);
      len    = (pick < 3) ? 255 : (pick < 12) ? $urandom_range(8, 40) : $urandom_range(0, 7);
      span   = (len + 1 < 4) ? len + 1 : 4;
      p      = $urandom_range(0, FILE_DEPTH - 1);
      q      = ($urandom_range(0, 4) == 0) ? p : $urandom_range(0, FILE_DEPTH - 1);
      upward = (op == KIND_SHIFT_R);
      use_q  = (op == KIND_ADD_STR) || (op == KIND_SUB_STR);
      issue(KIND_WRITE, LENGTH_REG_ADDR, len, 0, 0);
      if (op == KIND_ADD_ACC || op == KIND_SUB_ACC || $urandom_range(0, 1) == 0)
         issue(KIND_WRITE, ACC_REG_ADDR, pick_operand(), 0, 0);
      issue(KIND_SET_PTR, 0, 0, p, q);
      for (int i = 0; i < span; i++) begin
         issue(KIND_WRITE, upward ? p + i : p - i, pick_operand(), 0, 0);
         if (use_q) issue(KIND_WRITE, q - i, pick_operand(), 0, 0);
      end
      issue(op, 0, 0, 0, 0);
      if ($urandom_range(0, 9) < 3)
         issue(4'($urandom_range(KIND_ADD_ACC, KIND_SHIFT_R)), 0, 0, 0, 0);
      repeat ($urandom_range(0, 2))
         issue(KIND_READ, upward ? p + $urandom_range(0, span - 1) : p - $urandom_range(0, span - 1),
               0, 0, 0);
   endtask

   initial begin : stimulus
      drow_t    directed [$];
      outcome_t at_top;
      outcome_t read_top;
      int unsigned random_base;
      int unsigned stage;
      at_top   = {8'h00, 1'b0, 1'b0, 7'd127, 7'd127, 10'd0};
      read_top = {8'hff, 1'b0, 1'b0, 7'd127, 7'd127, 10'd0};
      stage    = 0;

      directed.push_back(row(KIND_READ, 0, 0, 0, 0, 1'b1, ALL_ZERO));
      directed.push_back(row(KIND_READ, 127, 0, 0, 0, 1'b1, ALL_ZERO));
      directed.push_back(row(KIND_UNUSED_FIRST, 127, 255, 127, 127, 1'b1, ALL_ZERO));
      directed.push_back(row(KIND_UNUSED_LAST, 0, 0, 0, 0, 1'b1, ALL_ZERO));
      directed.push_back(row(KIND_SET_PTR, 0, 0, 127, 127, 1'b1, at_top));
      directed.push_back(row(KIND_WRITE, 127, 255, 0, 0, 1'b1, at_top));
      directed.push_back(row(KIND_READ, 127, 0, 0, 0, 1'b1, read_top));
      directed.push_back(row(KIND_ADD_ACC, 0, 0, 0, 0, 1'b0, ALL_ZERO));
      // walk runs over the length and accumulator bytes
      directed.push_back(row(KIND_WRITE, LENGTH_REG_ADDR, 3, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_WRITE, ACC_REG_ADDR, 'h99, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_SET_PTR, 0, 0, 1, 126, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_ADD_STR, 0, 0, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_SUB_ACC, 0, 0, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_SET_PTR, 0, 0, 5, 5, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_SUB_STR, 0, 0, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_WRITE, 'h40, 'hab, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_SET_PTR, 0, 0, 'h40, 'h10, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_ADD_STR, 0, 0, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_SHIFT_L, 0, 0, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_SHIFT_R, 0, 0, 0, 0, 1'b0, ALL_ZERO));
      // longest walks
      directed.push_back(row(KIND_WRITE, LENGTH_REG_ADDR, 255, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_SHIFT_R, 0, 0, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_WRITE, LENGTH_REG_ADDR, 255, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_SUB_STR, 0, 0, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_READ, 'h40, 0, 0, 0, 1'b0, ALL_ZERO));
      directed.push_back(row(KIND_WRITE, LENGTH_REG_ADDR, 0, 0, 0, 1'b0, ALL_ZERO));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_item(directed[i].stim, directed[i].fixed, directed[i].want);

      random_base = items_sent;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         if (stage == 0 && items_sent - random_base >= 60) begin
            long_hold_req = 1'b1;
            stage++;
         end else if (stage == 1 && items_sent - random_base >= 350) begin
            req_valid <= 1'b0;
            // let the scoreboard log the last accepted item first
            @(negedge clock);
            wait (pending_outcomes.size() == 0);
            @(posedge clock);
            stage++;
         end else if (stage == 2 && items_sent - random_base >= 650) begin
            long_hold_req = 1'b1;
            stage++;
         end else if (stage == 3 && items_sent - random_base >= 820) begin
            req_valid <= 1'b0;
            @(negedge clock);
            wait (pending_outcomes.size() == 0);
            @(posedge clock);
            stage++;
         end
         if (items_sent - random_base >= RANDOM_ITEMS - QUIET_ITEMS && !long_hold_req)
            idle_on = 1'b0;
         if ($urandom_range(0, 9) < 8) begin
            issue_sequence();
         end else begin
            repeat ($urandom_range(1, 3))
               issue(4'($urandom_range(0, 15)), $urandom_range(0, 127), $urandom_range(0, 255),
                     $urandom_range(0, 127), $urandom_range(0, 127));
         end
      end

      req_valid <= 1'b0;
      @(negedge clock);
      wait (pending_outcomes.size() == 0);
      repeat (END_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("bcd_string_arithmetic_unit_core verification clean");
      end else begin
         $display("bcd_string_arithmetic_unit_core verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+src
src/bsau_pkg.sv
src/bsau_ctrl.sv
src/bsau_datapath.sv
src/bcd_string_arithmetic_unit_core.sv
src/bsau_checker.sv
verif/tb_bcd_string_arithmetic_unit_core.sv
